/* src/revolve_profile_vertex_macros.svh */
// Assertion macros for the vertex revolve block.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef REVOLVE_PROFILE_VERTEX_MACROS_SVH
`define REVOLVE_PROFILE_VERTEX_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RPV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("revolve_profile_vertex: assertion failed");

`define RPV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("revolve_profile_vertex: assertion failed");

`else

`define RPV_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define RPV_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/rpv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rpv_pkg;

	localparam int COORD_BITS    = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int RING_BITS     = 11;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam int TRIG_BITS  = 31;
	localparam int FRAC_SHIFT = 30;
	localparam int PROD_BITS  = 2 * TRIG_BITS + 1;

	localparam int POLY_STEPS   = 4;
	localparam int QSINE_STAGES = POLY_STEPS + 2;
	localparam int PIPE_STAGES  = QSINE_STAGES + 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ANGLE_BITS-1:0]        angle_t;
	typedef logic [RING_BITS-1:0]         ring_t;
	typedef logic [TRIG_BITS-1:0]         trig_t;
	typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
	typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;
	typedef logic [1:0]                   quad_t;

	localparam cfg_idx_t REG_START_ANGLE = cfg_idx_t'(0);
	localparam cfg_idx_t REG_STEP_ANGLE  = cfg_idx_t'(1);
	localparam cfg_idx_t REG_FULL_TURN   = cfg_idx_t'(2);

	localparam angle_t START_RESET = '0;
	localparam angle_t STEP_RESET  = angle_t'(1 << (ANGLE_BITS - 2));

	localparam quad_t QUAD_I   = 2'd0;
	localparam quad_t QUAD_II  = 2'd1;
	localparam quad_t QUAD_III = 2'd2;
	localparam quad_t QUAD_IV  = 2'd3;

	localparam trig_t Q30_ONE  = trig_t'(1073741824);
	localparam trig_t Q30_HALF = trig_t'(536870912);
	localparam trig_t SIN_C1   = trig_t'(1686629713);
	localparam trig_t SIN_C3   = trig_t'(693598668);
	localparam trig_t SIN_C5   = trig_t'(85569306);
	localparam trig_t SIN_C7   = trig_t'(5026995);
	localparam trig_t SIN_C9   = trig_t'(172272);

	localparam trig_t POLY_COEF [POLY_STEPS] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

	typedef struct packed {
		logic   pass;
		quad_t  quad;
		coord_t radius;
		coord_t height;
		coord_t depth;
	} side_t;

endpackage

`default_nettype wire

/* src/rpv_angle.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpv_angle (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire rpv_pkg::ring_t  ring,
	input  wire rpv_pkg::coord_t radius,
	input  wire rpv_pkg::coord_t height,
	input  wire rpv_pkg::coord_t depth,
	input  wire rpv_pkg::angle_t start_angle,
	input  wire rpv_pkg::angle_t step_angle,
	input  wire logic            full_turn,
	output logic                 valid_s1,
	output rpv_pkg::angle_t      angle_s1,
	output rpv_pkg::side_t       side_s1
);

	localparam int AW = rpv_pkg::ANGLE_BITS;
	localparam int MW = rpv_pkg::RING_BITS + rpv_pkg::ANGLE_BITS;

	logic [MW-1:0]   ring_prod;
	rpv_pkg::angle_t angle_next;

	assign ring_prod  = MW'(ring) * MW'(step_angle);
	assign angle_next = start_angle + ring_prod[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		angle_s1       <= angle_next;
		side_s1.pass   <= full_turn && (ring == '0);
		side_s1.quad   <= angle_next[AW-1 -: 2];
		side_s1.radius <= radius;
		side_s1.height <= height;
		side_s1.depth  <= depth;
	end

endmodule

`default_nettype wire

/* src/rpv_qsine.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpv_qsine (
	input  wire logic           clk,
	input  wire rpv_pkg::trig_t u,
	output rpv_pkg::trig_t      sine
);

	localparam int PW    = rpv_pkg::PROD_BITS;
	localparam int STEPS = rpv_pkg::POLY_STEPS;

	function automatic rpv_pkg::trig_t q30_mul(rpv_pkg::trig_t a, rpv_pkg::trig_t b);
		logic [PW-1:0] p;
		p = PW'(a) * PW'(b) + PW'(rpv_pkg::Q30_HALF);
		return p[rpv_pkg::FRAC_SHIFT +: rpv_pkg::TRIG_BITS];
	endfunction

	rpv_pkg::trig_t u_s    [STEPS+1];
	rpv_pkg::trig_t usq_s  [STEPS];
	rpv_pkg::trig_t poly_s [STEPS];
	rpv_pkg::trig_t fin_prod;

	always_ff @(posedge clk) begin
		u_s[0]   <= u;
		usq_s[0] <= q30_mul(u, u);
	end

	// Horner steps of the odd polynomial, one coefficient per stage.
	for (genvar j = 0; j < STEPS; j++) begin : g_poly
		rpv_pkg::trig_t prev;
		if (j == 0) begin : g_first
			assign prev = rpv_pkg::SIN_C9;
		end else begin : g_next
			assign prev = poly_s[j-1];
		end
		always_ff @(posedge clk) begin
			poly_s[j] <= rpv_pkg::POLY_COEF[j] - q30_mul(usq_s[j], prev);
			u_s[j+1]  <= u_s[j];
		end
		if (j < STEPS - 1) begin : g_sq
			always_ff @(posedge clk) begin
				usq_s[j+1] <= usq_s[j];
			end
		end
	end

	assign fin_prod = q30_mul(u_s[STEPS], poly_s[STEPS-1]);

	always_ff @(posedge clk) begin
		sine <= (fin_prod > rpv_pkg::Q30_ONE) ? rpv_pkg::Q30_ONE : fin_prod;
	end

endmodule

`default_nettype wire

/* src/rpv_scale.sv */
`timescale 1ns / 1ps
`default_nettype none

module rpv_scale (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire rpv_pkg::side_t  side,
	input  wire rpv_pkg::trig_t  sine,
	input  wire rpv_pkg::trig_t  cosine,
	output logic                 done,
	output rpv_pkg::coord_t      out_x,
	output rpv_pkg::coord_t      out_y,
	output rpv_pkg::coord_t      out_z
);

	localparam int CW = rpv_pkg::COORD_BITS;
	localparam int XW = CW + rpv_pkg::TRIG_BITS;
	localparam int RW = XW + 1;
	localparam int MW = CW + 2;

	localparam logic [MW-1:0] POS_LIM = MW'((1 << (CW - 1)) - 1);
	localparam logic [MW-1:0] NEG_LIM = MW'(1 << (CW - 1));

	function automatic rpv_pkg::coord_t sat_coord(logic [RW-1:0] prod_r, logic neg);
		logic [MW-1:0] m;
		logic [MW-1:0] nm;
		m  = prod_r[rpv_pkg::FRAC_SHIFT +: MW];
		nm = -m;
		if (neg) begin
			return (m > NEG_LIM) ? NEG_LIM[CW-1:0] : nm[CW-1:0];
		end
		return (m > POS_LIM) ? POS_LIM[CW-1:0] : m[CW-1:0];
	endfunction

	logic [CW-1:0]   mag;
	rpv_pkg::trig_t  tx;
	rpv_pkg::trig_t  tz;
	logic            nx;
	logic            nz;

	logic            valid_s8;
	rpv_pkg::side_t  side_s8;
	logic [XW-1:0]   prod_x_s8;
	logic [XW-1:0]   prod_z_s8;
	logic            neg_x_s8;
	logic            neg_z_s8;

	logic [RW-1:0]   rnd_x;
	logic [RW-1:0]   rnd_z;

	assign mag = side.radius[CW-1] ? CW'(-side.radius) : CW'(side.radius);

	always_comb begin
		unique case (side.quad)
			rpv_pkg::QUAD_I: begin
				tx = cosine; nx = 1'b0;
				tz = sine;   nz = 1'b0;
			end
			rpv_pkg::QUAD_II: begin
				tx = sine;   nx = 1'b1;
				tz = cosine; nz = 1'b0;
			end
			rpv_pkg::QUAD_III: begin
				tx = cosine; nx = 1'b1;
				tz = sine;   nz = 1'b1;
			end
			default: begin
				tx = sine;   nx = 1'b0;
				tz = cosine; nz = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s8 <= valid_in;
			done     <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		side_s8   <= side;
		prod_x_s8 <= XW'(mag) * XW'(tx);
		prod_z_s8 <= XW'(mag) * XW'(tz);
		neg_x_s8  <= nx;
		neg_z_s8  <= nz;
	end

	assign rnd_x = RW'(prod_x_s8) + RW'(rpv_pkg::Q30_HALF);
	assign rnd_z = RW'(prod_z_s8) + RW'(rpv_pkg::Q30_HALF);

	always_ff @(posedge clk) begin
		out_x <= side_s8.pass ? side_s8.radius : sat_coord(rnd_x, neg_x_s8);
		out_y <= side_s8.height;
		out_z <= side_s8.pass ? side_s8.depth : sat_coord(rnd_z, neg_z_s8);
	end

endmodule

`default_nettype wire

/* src/revolve_profile_vertex.sv */
// Channel  Handshake                Word
// vertex   start, busy (always 0)   ring, radius, height, depth
// config   cfg_valid, cfg_ready     cfg_index, cfg_data
// result   done (one-cycle strobe)  out_x, out_y, out_z
//
// One vertex enters per cycle; its word passes the angle stage, the sine lanes and the scale stages.
// X and z come from the two polynomial sine lanes, one Horner step per stage.
// Reset clears the valid bits and loads the register defaults.
// Nothing inside stalls; configuration is taken at any cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "revolve_profile_vertex_macros.svh"

module revolve_profile_vertex (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire rpv_pkg::ring_t     ring,
	input  wire rpv_pkg::coord_t    radius,
	input  wire rpv_pkg::coord_t    height,
	input  wire rpv_pkg::coord_t    depth,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire rpv_pkg::cfg_idx_t  cfg_index,
	input  wire rpv_pkg::cfg_data_t cfg_data,
	output logic                    done,
	output rpv_pkg::coord_t         out_x,
	output rpv_pkg::coord_t         out_y,
	output rpv_pkg::coord_t         out_z
);

	localparam int AW = rpv_pkg::ANGLE_BITS;
	localparam int NS = rpv_pkg::QSINE_STAGES;
	localparam int PAD = rpv_pkg::FRAC_SHIFT - (AW - 2);

	rpv_pkg::angle_t start_angle_q;
	rpv_pkg::angle_t step_angle_q;
	logic            full_turn_q;

	logic            valid_s1;
	rpv_pkg::angle_t angle_s1;
	rpv_pkg::side_t  side_s1;

	rpv_pkg::trig_t  u_sin;
	rpv_pkg::trig_t  u_cos;
	rpv_pkg::trig_t  sine_s7;
	rpv_pkg::trig_t  cosine_s7;

	logic [NS-1:0]   valid_stg_s;
	rpv_pkg::side_t  side_stg_s [NS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= rpv_pkg::START_RESET;
			step_angle_q  <= rpv_pkg::STEP_RESET;
			full_turn_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpv_pkg::REG_START_ANGLE: start_angle_q <= AW'(cfg_data);
				rpv_pkg::REG_STEP_ANGLE:  step_angle_q  <= AW'(cfg_data);
				rpv_pkg::REG_FULL_TURN:   full_turn_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rpv_angle u_angle (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (start && !busy),
		.ring        (ring),
		.radius      (radius),
		.height      (height),
		.depth       (depth),
		.start_angle (start_angle_q),
		.step_angle  (step_angle_q),
		.full_turn   (full_turn_q),
		.valid_s1    (valid_s1),
		.angle_s1    (angle_s1),
		.side_s1     (side_s1)
	);

	// The low angle bits form a Q30 fraction of the quadrant.
	assign u_sin = rpv_pkg::trig_t'({angle_s1[AW-3:0], PAD'(0)});
	assign u_cos = rpv_pkg::Q30_ONE - u_sin;

	rpv_qsine u_sin_lane (
		.clk  (clk),
		.u    (u_sin),
		.sine (sine_s7)
	);

	rpv_qsine u_cos_lane (
		.clk  (clk),
		.u    (u_cos),
		.sine (cosine_s7)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_stg_s <= '0;
		end else begin
			valid_stg_s <= {valid_stg_s[NS-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		side_stg_s[0] <= side_s1;
		for (int k = 1; k < NS; k++) begin
			side_stg_s[k] <= side_stg_s[k-1];
		end
	end

	rpv_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_stg_s[NS-1]),
		.side     (side_stg_s[NS-1]),
		.sine     (sine_s7),
		.cosine   (cosine_s7),
		.done     (done),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z)
	);

	`RPV_ASSERT_IMP(a_word_latency, clk, arst_n, start && !busy, ##(rpv_pkg::PIPE_STAGES) done)
	`RPV_ASSERT_IMP(a_no_stray_word, clk, arst_n, !(start && !busy), ##(rpv_pkg::PIPE_STAGES) !done)
	`RPV_ASSERT_NXT(a_pass_ring, clk, arst_n, start && !busy, side_s1.pass == $past(full_turn_q && (ring == '0)))

endmodule

`default_nettype wire
